// ===== hdl/sphm_pkg.sv =====
// ----------------------------------------------------------------------------
// sphm_pkg
// Shared types and constants of the sphere mesh vertex generator.
// ----------------------------------------------------------------------------
package sphm_pkg;

  localparam int PhaseW = 17;
  localparam int SineW  = 15;
  localparam int IdxW   = 8;
  localparam int AddrW  = 5;
  localparam int NumCorners = 6;

  localparam logic [PhaseW-1:0] QuarterTurn = 17'h08000;
  localparam logic signed [32:0] RoundQ14 = 33'sd8192;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_RING_STEP   = 3'd0,
    REG_SECTOR_STEP = 3'd1,
    REG_SCALE_X     = 3'd2,
    REG_SCALE_Y     = 3'd3,
    REG_SCALE_Z     = 3'd4,
    REG_TEX_ORIGIN  = 3'd5,
    REG_TEX_STEP    = 3'd6,
    REG_MIRROR      = 3'd7
  } reg_idx_t;

  localparam logic [2:0] LastCorner = 3'd5;

  // grid point of one vertex within its cell
  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] r;
    logic [IdxW-1:0] s;
    logic [2:0]      corner;
  } vtx_req_t;

  function automatic logic corner_dr(input logic [2:0] k);
    case (k)
      3'd1, 3'd2, 3'd4: corner_dr = 1'b1;
      default:          corner_dr = 1'b0;
    endcase
  endfunction

  function automatic logic corner_ds(input logic [2:0] k, input logic mir);
    logic d;
    case (k)
      3'd2, 3'd4, 3'd5: d = 1'b1;
      default:          d = 1'b0;
    endcase
    corner_ds = d ^ mir;
  endfunction

endpackage

// ===== hdl/sphm_sine_rom.sv =====
// ----------------------------------------------------------------------------
// sphm_sine_rom
// Quarter-wave sine table, Q1.14, two registered read ports.
// ----------------------------------------------------------------------------
module sphm_sine_rom import sphm_pkg::*; #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [SINE_TABLE_BITS:0] addr_a,
  input  logic [SINE_TABLE_BITS:0] addr_b,
  output logic [SineW-1:0]         data_a_r,
  output logic [SineW-1:0]         data_b_r
);

  localparam int Qtr = 1 << SINE_TABLE_BITS;

  typedef logic [SineW-1:0] tab_t [0:Qtr];

  // shift and subtract quotient, only evaluated while building the table
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q, rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      q   = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q   = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic tab_t build_tab();
    tab_t       t;
    longint unsigned x, x2, term;
    longint     sum, r;
    for (int i = 0; i <= Qtr; i++) begin
      x    = (64'd1686629713 * longint'(i)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 9; k++) begin
        term = udiv((term * x2) >> 30, longint'((2 * k) * (2 * k + 1)));
        if ((k & 1) == 1) sum = sum - longint'(term);
        else              sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (sum + 32768) >>> 16;
      if (r > 16384) r = 16384;
      t[i] = r[SineW-1:0];
    end
    return t;
  endfunction

  localparam tab_t SineTab = build_tab();

  always_ff @(posedge clk) begin
    if (en) begin
      data_a_r <= SineTab[addr_a];
      data_b_r <= SineTab[addr_b];
    end
  end

endmodule

// ===== hdl/sphm_cell_seq.sv =====
// ----------------------------------------------------------------------------
// sphm_cell_seq
// Takes one grid cell and walks its six triangle corners, one per cycle while en is high.
// ----------------------------------------------------------------------------
module sphm_cell_seq import sphm_pkg::*; #(
  parameter int MAX_GRID = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            mirror,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [IdxW-1:0] in_ring_index,
  input  logic [IdxW-1:0] in_sector_index,
  output vtx_req_t        req
);

  logic            busy_r, busy_nxt;
  logic [2:0]      k_r, k_nxt;
  logic [IdxW-1:0] r_r, s_r;
  logic            in_grid, take;

  assign in_grid = (32'(in_ring_index) < 32'(MAX_GRID - 1)) &&
                   (32'(in_sector_index) < 32'(MAX_GRID - 1));
  assign in_stall = !en || (busy_r && (k_r != LastCorner));
  assign take = in_valid && !in_stall;

  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    if (en) begin
      if (busy_r && (k_r != LastCorner)) begin
        k_nxt = k_r + 3'd1;
      end else begin
        // out-of-grid cells are taken and dropped
        busy_nxt = take && in_grid;
        k_nxt    = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      r_r <= in_ring_index;
      s_r <= in_sector_index;
    end
  end

  assign req.valid  = busy_r;
  assign req.r      = r_r + IdxW'(corner_dr(k_r));
  assign req.s      = s_r + IdxW'(corner_ds(k_r, mirror));
  assign req.corner = k_r;

endmodule

// ===== hdl/sphere_mesh_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// sphere_mesh_vertex_generator
// Flow: a transfer loads the corner sequencer, and the cell's vertices leave
// on out_valid in order; the next cell is taken during the last corner.
// Throughput: one vertex per cycle unless out_stall holds the pipeline, set
// by the corner sequencer feeding the single vertex pipeline.
// Reset: synchronous active-low rst_n clears valid bits, the sequencer and
// the registers to their defaults (scales 256, all else 0).
// ----------------------------------------------------------------------------
module sphere_mesh_vertex_generator import sphm_pkg::*; #(
  parameter int MAX_GRID        = 256,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_ring_index,
  input  logic [7:0]         in_sector_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic signed [15:0] out_pos_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic [15:0]        out_tex_u,
  output logic [15:0]        out_tex_v,
  output logic [2:0]         out_corner,
  output logic               out_last_vertex
);

  localparam int Sh  = 15 - SINE_TABLE_BITS;
  localparam int Aw  = SINE_TABLE_BITS + 1;
  localparam logic [Aw-1:0] Qtr = Aw'(1) << SINE_TABLE_BITS;

  // configuration registers
  logic [15:0]        ring_step_r, sector_step_r;
  logic signed [15:0] scale_x_r, scale_y_r, scale_z_r;
  logic [31:0]        tex_origin_r, tex_step_r;
  logic               mirror_r;
  reg_idx_t           widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_step_r   <= 16'd0;
      sector_step_r <= 16'd0;
      scale_x_r     <= 16'sd256;
      scale_y_r     <= 16'sd256;
      scale_z_r     <= 16'sd256;
      tex_origin_r  <= 32'd0;
      tex_step_r    <= 32'd0;
      mirror_r      <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (widx)
        REG_RING_STEP:   ring_step_r   <= pwdata[15:0];
        REG_SECTOR_STEP: sector_step_r <= pwdata[15:0];
        REG_SCALE_X:     scale_x_r     <= pwdata[15:0];
        REG_SCALE_Y:     scale_y_r     <= pwdata[15:0];
        REG_SCALE_Z:     scale_z_r     <= pwdata[15:0];
        REG_TEX_ORIGIN:  tex_origin_r  <= pwdata;
        REG_TEX_STEP:    tex_step_r    <= pwdata;
        REG_MIRROR:      mirror_r      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_RING_STEP:   prdata = {16'd0, ring_step_r};
      REG_SECTOR_STEP: prdata = {16'd0, sector_step_r};
      REG_SCALE_X:     prdata = {16'd0, scale_x_r};
      REG_SCALE_Y:     prdata = {16'd0, scale_y_r};
      REG_SCALE_Z:     prdata = {16'd0, scale_z_r};
      REG_TEX_ORIGIN:  prdata = tex_origin_r;
      REG_TEX_STEP:    prdata = tex_step_r;
      REG_MIRROR:      prdata = {31'd0, mirror_r};
      default:         prdata = 32'd0;
    endcase
  end

  // whole pipeline moves unless the output holds an untaken transfer
  logic     en;
  vtx_req_t req;
  logic     v1_r, v2_r, v3_r, v4_r, v5_r;

  assign en = !v5_r || !out_stall;

  sphm_cell_seq #(.MAX_GRID(MAX_GRID)) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .mirror          (mirror_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ring_index   (in_ring_index),
    .in_sector_index (in_sector_index),
    .req             (req)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= req.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // stage 1: phases and texture coordinates
  logic [PhaseW-1:0] th1_r, ph1_r;
  logic [15:0]       u1_r, v1t_r;
  logic [2:0]        c1_r;
  logic [23:0]       th_prod, ph_prod, u_prod, v_prod;

  assign th_prod = 24'(req.r) * 24'(ring_step_r);
  assign ph_prod = 24'(req.s) * 24'(sector_step_r);
  assign u_prod  = 24'(req.s) * 24'(tex_step_r[15:0]);
  assign v_prod  = 24'(req.r) * 24'(tex_step_r[31:16]);

  always_ff @(posedge clk) begin
    if (en) begin
      th1_r <= th_prod[PhaseW-1:0];
      ph1_r <= {ph_prod[15:0], 1'b0};
      u1_r  <= tex_origin_r[15:0] + u_prod[15:0];
      v1t_r <= tex_origin_r[31:16] + v_prod[15:0];
      c1_r  <= req.corner;
    end
  end

  // stage 2: table lookups
  function automatic logic [Aw-1:0] tab_addr(input logic [PhaseW-1:0] p);
    logic [15:0]   rnd;
    logic [Aw-1:0] idx;
    rnd = {1'b0, p[14:0]} + (16'd1 << (Sh - 1));
    idx = Aw'(rnd >> Sh);
    tab_addr = p[15] ? Qtr - idx : idx;
  endfunction

  logic [PhaseW-1:0] thc, phc;
  logic [SineW-1:0]  st_raw, ct_raw, sp_raw, cp_raw;
  logic [1:0]        qst2_r, qct2_r, qsp2_r, qcp2_r;
  logic [15:0]       u2_r, v2t_r;
  logic [2:0]        c2_r;

  assign thc = th1_r + QuarterTurn;
  assign phc = ph1_r + QuarterTurn;

  sphm_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom_th (
    .clk      (clk),
    .en       (en),
    .addr_a   (tab_addr(th1_r)),
    .addr_b   (tab_addr(thc)),
    .data_a_r (st_raw),
    .data_b_r (ct_raw)
  );

  sphm_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom_ph (
    .clk      (clk),
    .en       (en),
    .addr_a   (tab_addr(ph1_r)),
    .addr_b   (tab_addr(phc)),
    .data_a_r (sp_raw),
    .data_b_r (cp_raw)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      qst2_r <= th1_r[16:15];
      qct2_r <= thc[16:15];
      qsp2_r <= ph1_r[16:15];
      qcp2_r <= phc[16:15];
      u2_r   <= u1_r;
      v2t_r  <= v1t_r;
      c2_r   <= c1_r;
    end
  end

  // stage 3: quadrant sign
  function automatic logic signed [15:0] apply_sign(input logic [SineW-1:0] m,
                                                    input logic [1:0] q);
    logic signed [15:0] v;
    v = signed'({1'b0, m});
    apply_sign = q[1] ? -v : v;
  endfunction

  logic signed [15:0] st3_r, ct3_r, sp3_r, cp3_r;
  logic [15:0]        u3_r, v3t_r;
  logic [2:0]         c3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      st3_r <= apply_sign(st_raw, qst2_r);
      ct3_r <= apply_sign(ct_raw, qct2_r);
      sp3_r <= apply_sign(sp_raw, qsp2_r);
      cp3_r <= apply_sign(cp_raw, qcp2_r);
      u3_r  <= u2_r;
      v3t_r <= v2t_r;
      c3_r  <= c2_r;
    end
  end

  // stage 4: normal products
  logic signed [32:0] nx_prod, ny_prod;
  logic signed [15:0] nx_rnd, ny_rnd;
  logic signed [15:0] nx4_r, ny4_r, nz4_r;
  logic [15:0]        u4_r, v4t_r;
  logic [2:0]         c4_r;

  assign nx_prod = 33'(cp3_r * st3_r) + RoundQ14;
  assign ny_prod = 33'(sp3_r * st3_r) + RoundQ14;
  assign nx_rnd  = 16'(nx_prod >>> 14);
  assign ny_rnd  = 16'(ny_prod >>> 14);

  always_ff @(posedge clk) begin
    if (en) begin
      nx4_r <= mirror_r ? -nx_rnd : nx_rnd;
      ny4_r <= ny_rnd;
      nz4_r <= ct3_r;
      u4_r  <= u3_r;
      v4t_r <= v3t_r;
      c4_r  <= c3_r;
    end
  end

  // stage 5: scaled positions, saturated, into the output register
  function automatic logic signed [15:0] scale_sat(input logic signed [15:0] n,
                                                   input logic signed [15:0] k);
    logic signed [32:0] p;
    logic signed [18:0] q;
    p = 33'(n * k) + RoundQ14;
    q = 19'(p >>> 14);
    if (q > 19'sd32767)       scale_sat = 16'sh7fff;
    else if (q < -19'sd32768) scale_sat = 16'sh8000;
    else                      scale_sat = q[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      out_pos_x       <= scale_sat(nx4_r, scale_x_r);
      out_pos_y       <= scale_sat(ny4_r, scale_y_r);
      out_pos_z       <= scale_sat(nz4_r, scale_z_r);
      out_norm_x      <= nx4_r;
      out_norm_y      <= ny4_r;
      out_norm_z      <= nz4_r;
      out_tex_u       <= u4_r;
      out_tex_v       <= v4t_r;
      out_corner      <= c4_r;
      out_last_vertex <= (c4_r == LastCorner);
    end
  end

  assign out_valid = v5_r;

  // checks
  a_seq_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (req.valid && req.corner != LastCorner) |-> in_stall)
    else $error("cell taken while corners still pending");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_norm_x >= -16'sd16384 && out_norm_x <= 16'sd16384 &&
                   out_norm_y >= -16'sd16384 && out_norm_y <= 16'sd16384))
    else $error("normal out of unit range");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(th1_r) && $stable(nx4_r) && $stable(v4_r)))
    else $error("pipeline moved during stall");

endmodule

// ===== bench/tb_sphere_mesh_vertex_generator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sphere_mesh_vertex_generator
// Self-checking bench: cells are sent through a queue-fed driver, every
// vertex is predicted from the register settings and compared in order.
// ----------------------------------------------------------------------------
module tb_sphere_mesh_vertex_generator;
  import sphm_pkg::*;

  typedef struct {
    logic [7:0] r;
    logic [7:0] s;
  } cell_t;

  typedef struct {
    logic signed [15:0] px, py, pz, nx, ny, nz;
    logic [15:0]        u, v;
    logic [2:0]         corner;
    logic               last;
  } vertex_t;

  localparam int TabBits = 10;
  localparam int Qtr     = 1 << TabBits;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_ring_index = '0, in_sector_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_norm_x, out_norm_y, out_norm_z;
  logic [15:0] out_tex_u, out_tex_v;
  logic [2:0] out_corner;
  logic out_last_vertex;

  sphere_mesh_vertex_generator u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cell_t   pending_cells[$];
  vertex_t expected_vertices[$];
  int      sine_lut[Qtr+1];
  int      n_err = 0, n_cells = 0, n_verts = 0;
  bit      quiet = 1'b0;
  int      hold_cycles = 0;

  // register shadow
  logic [15:0] m_ring_step = 0, m_sector_step = 0;
  logic signed [15:0] m_scale_x = 256, m_scale_y = 256, m_scale_z = 256;
  logic [31:0] m_tex_origin = 0, m_tex_step = 0;
  logic m_mirror = 0;

  function automatic longint rshift_round(longint v, int n);
    longint t;
    t = v + (64'sd1 <<< (n - 1));
    return t >>> n;  // arithmetic shift is floor
  endfunction

  function automatic void build_sine_lut();
    longint unsigned x, x2, term;
    longint sum, r;
    for (int i = 0; i <= Qtr; i++) begin
      x = (64'd1686629713 * i) / Qtr;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int k = 1; k <= 9; k++) begin
        term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
        if (k & 1) sum -= term;
        else sum += term;
      end
      if (sum < 0) sum = 0;
      r = (sum + 32768) >>> 16;
      if (r > 16384) r = 16384;
      sine_lut[i] = int'(r);
    end
  endfunction

  function automatic int phase_sine(logic [16:0] p);
    int idx, v;
    idx = (p[14:0] + (1 << (15 - TabBits - 1))) >> (15 - TabBits);
    if (idx > Qtr) idx = Qtr;
    v = p[15] ? sine_lut[Qtr - idx] : sine_lut[idx];
    return p[16] ? -v : v;
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic vertex_t grid_vertex(int r, int s, int k);
    vertex_t vx;
    logic [16:0] th, ph;
    longint st, ct, sp, cp, nx, ny, nz;
    th = 17'(r * m_ring_step);
    ph = {(16'(s * m_sector_step)), 1'b0};
    st = phase_sine(th);
    ct = phase_sine(th + 17'h08000);
    sp = phase_sine(ph);
    cp = phase_sine(ph + 17'h08000);
    nx = rshift_round(cp * st, 14);
    ny = rshift_round(sp * st, 14);
    nz = ct;
    if (m_mirror) nx = -nx;
    vx.px = sat16(rshift_round(nx * m_scale_x, 14));
    vx.py = sat16(rshift_round(ny * m_scale_y, 14));
    vx.pz = sat16(rshift_round(nz * m_scale_z, 14));
    vx.nx = nx[15:0];
    vx.ny = ny[15:0];
    vx.nz = nz[15:0];
    vx.u = 16'(m_tex_origin[15:0] + s * m_tex_step[15:0]);
    vx.v = 16'(m_tex_origin[31:16] + r * m_tex_step[31:16]);
    vx.corner = 3'(k);
    vx.last = (k == 5);
    return vx;
  endfunction

  function automatic void predict_cell(cell_t c);
    int dr, ds;
    if (c.r >= 255 || c.s >= 255) return;
    for (int k = 0; k < NumCorners; k++) begin
      dr = (k == 1 || k == 2 || k == 4);
      ds = (k == 2 || k == 4 || k == 5);
      if (m_mirror) ds = 1 - ds;
      expected_vertices.push_back(grid_vertex(c.r + dr, c.s + ds, k));
    end
  endfunction

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AddrW'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_RING_STEP:   m_ring_step = val[15:0];
      REG_SECTOR_STEP: m_sector_step = val[15:0];
      REG_SCALE_X:     m_scale_x = val[15:0];
      REG_SCALE_Y:     m_scale_y = val[15:0];
      REG_SCALE_Z:     m_scale_z = val[15:0];
      REG_TEX_ORIGIN:  m_tex_origin = val;
      REG_TEX_STEP:    m_tex_step = val;
      default:         m_mirror = val[0];
    endcase
  endtask

  // driver: an accepted cell is predicted at its transfer edge
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_cell('{in_ring_index, in_sector_index});
        n_cells++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_cells.size() > 0) begin
          cell_t c;
          c = pending_cells.pop_front();
          in_valid <= 1'b1;
          in_ring_index <= c.r;
          in_sector_index <= c.s;
          if (!quiet && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        vertex_t e;
        n_verts++;
        if (expected_vertices.size() == 0) begin
          $display("%0t: unexpected vertex corner %0d", $time, out_corner);
          n_err++;
        end else begin
          e = expected_vertices.pop_front();
          if ({out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z,
               out_tex_u, out_tex_v, out_corner, out_last_vertex} !==
              {e.px, e.py, e.pz, e.nx, e.ny, e.nz, e.u, e.v, e.corner, e.last}) begin
            $display("%0t: mismatch exp pos %0d %0d %0d nrm %0d %0d %0d uv %h %h c %0d l %0d",
                     $time, e.px, e.py, e.pz, e.nx, e.ny, e.nz, e.u, e.v, e.corner, e.last);
            $display("%0t:          act pos %0d %0d %0d nrm %0d %0d %0d uv %h %h c %0d l %0d",
                     $time, out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y,
                     out_norm_z, out_tex_u, out_tex_v, out_corner, out_last_vertex);
            n_err++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic drain();
    while (pending_cells.size() > 0 || in_valid || expected_vertices.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic cell_t random_cell();
    cell_t c;
    c.r = $urandom_range(0, 6) == 0 ? 8'($urandom_range(250, 255)) : 8'($urandom);
    c.s = $urandom_range(0, 6) == 0 ? 8'($urandom_range(250, 255)) : 8'($urandom);
    if ($urandom_range(0, 9) != 0) begin
      if (c.r >= 255) c.r = 254;
      if (c.s >= 255) c.s = 254;
    end
    return c;
  endfunction

  task automatic random_settings(bit mir);
    reg_write(REG_RING_STEP, $urandom);
    reg_write(REG_SECTOR_STEP, $urandom);
    reg_write(REG_SCALE_X, $urandom);
    reg_write(REG_SCALE_Y, $urandom_range(0, 3) == 0 ? 32'h8000 : $urandom);
    reg_write(REG_SCALE_Z, $urandom_range(0, 3) == 0 ? 32'h7fff : $urandom);
    reg_write(REG_TEX_ORIGIN, $urandom);
    reg_write(REG_TEX_STEP, $urandom);
    reg_write(REG_MIRROR, mir);
  endtask

  initial begin
    build_sine_lut();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: reset settings, then a 63-ring by 127-sector sphere
    pending_cells.push_back('{8'd0, 8'd0});
    pending_cells.push_back('{8'd254, 8'd254});
    pending_cells.push_back('{8'd255, 8'd0});
    pending_cells.push_back('{8'd0, 8'd255});
    drain();
    reg_write(REG_RING_STEP, 32'd1040);
    reg_write(REG_SECTOR_STEP, 32'd516);
    reg_write(REG_SCALE_X, 32'h7fff);
    reg_write(REG_SCALE_Y, 32'h8000);
    reg_write(REG_SCALE_Z, 32'h0400);
    reg_write(REG_TEX_ORIGIN, 32'hffff_ffff);
    reg_write(REG_TEX_STEP, 32'hffff_ffff);
    pending_cells.push_back('{8'd0, 8'd0});
    pending_cells.push_back('{8'd31, 8'd63});
    pending_cells.push_back('{8'd62, 8'd126});
    pending_cells.push_back('{8'd254, 8'd0});
    pending_cells.push_back('{8'd170, 8'd85});
    drain();
    reg_write(REG_MIRROR, 32'd1);
    pending_cells.push_back('{8'd0, 8'd0});
    pending_cells.push_back('{8'd62, 8'd254});
    pending_cells.push_back('{8'd85, 8'd170});
    pending_cells.push_back('{8'd255, 8'd255});
    drain();
    reg_write(REG_RING_STEP, 32'hffff);
    reg_write(REG_SECTOR_STEP, 32'hffff);
    reg_write(REG_MIRROR, 32'd0);
    pending_cells.push_back('{8'd1, 8'd1});
    pending_cells.push_back('{8'd254, 8'd254});
    drain();

    // random phases, the first with a long receiver hold-off
    for (int ph = 0; ph < 6; ph++) begin
      random_settings(ph[0]);
      if (ph == 0) hold_cycles = 300;
      if (ph == 5) quiet = 1'b1;
      for (int i = 0; i < 58; i++) pending_cells.push_back(random_cell());
      drain();
    end

    $display("covered %0d cells and %0d vertices over reset, directed and random settings",
             n_cells, n_verts);
    $display("including both corner orders, saturating scales and out-of-grid cells");
    if (n_err == 0) begin
      $display("** sphere_mesh_vertex_generator: PASSED **");
    end else begin
      $display("** sphere_mesh_vertex_generator: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("** sphere_mesh_vertex_generator: FAILED **");
    $finish;
  end

endmodule
